>>> src/sha_pkg.sv
// Shared types and constants of the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha_pkg;
    localparam logic [1:0] OP_ABSORB = 2'd0;
    localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        begin
            k = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            return k[i];
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Request from the buffer control to the compression core.
    typedef struct packed {
        logic start;
    } core_req_t;

    typedef struct packed {
        logic busy;
    } core_stat_t;
endpackage

>>> src/sha_core.sv
// Compression core: one round per cycle, rolling 16-word schedule.
`timescale 1ns / 1ps
module sha_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha_pkg::core_req_t  req,
    output sha_pkg::core_stat_t stat,
    output logic [3:0]          wd_addr,
    input  logic [31:0]         wd_data,
    input  logic                chain_clear,
    input  logic [2:0]          chain_idx,
    output logic [31:0]         chain_word
);
    import sha_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_ADD = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_new, w_cur, t1, t2, s0, s1;

    assign wd_addr = cnt_reg[3:0];
    assign stat.busy = (state_reg != ST_IDLE);
    assign chain_word = chain_reg[chain_idx];

    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (cnt_reg < 7'd16) ? w_reg[0] : w_new;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + round_k(cnt_reg[5:0]) + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    state_next = ST_LOAD;
                    cnt_next = '0;
                end
            end
            ST_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16) begin
                    state_next = ST_ROUND;
                    cnt_next = '0;
                end
            end
            ST_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = ST_ADD;
            end
            ST_ADD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Load word (cnt-1), read from the block memory in the cycle after its address; round data shifts w_reg.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && cnt_reg != 7'd0) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wd_data;
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end else if (state_reg == ST_IDLE) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= chain_reg[i];
        end
    end

    // Rounds 0..15 take the loaded words from w_reg[0] and rotate them through,
    // so the window holds w[i-16..i-1] from round 16 on.

    always_ff @(posedge aclk) begin
        if (!aresetn || chain_clear) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= init_hash(3'(i));
        end else if (state_reg == ST_ADD) begin
            for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + v_reg[i];
        end
    end
endmodule

>>> src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: buffer memory, padding control, digest output.
`timescale 1ns / 1ps
// Usage:
//   Input stream: one transaction per message byte. s_axis_tuser carries the op
//   (0 absorb, 1 absorb then finish, 2 finish without byte), s_axis_tdata the byte.
//   Output stream: eight transactions per finish, digest words H0..H7, with the
//   word index in m_axis_tuser and tlast on the eighth word.
// Flow: absorb bytes are taken back to back, except the 64th byte of a block which
//   starts a compression (reading the block memory as 16 words, 64 rounds, one add);
//   no byte is taken meanwhile.
//   A finish writes the padding one byte per cycle into the block memory, runs
//   one or two compressions and then presents the eight words.
// Reset: synchronous, active low; the chaining words return to their initial
//   values, the length and fill counters clear. The block memory is not cleared.
// Stall: while the receiver holds m_axis_tready low the current word holds and
//   no further input is taken until the last word has been delivered.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_PAD = 3'd2;
    localparam logic [2:0] ST_PHASH = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;       // finish pending after a full block
    logic        mark_reg, mark_next;     // 0x80 marker already written
    logic        lenblk_reg, lenblk_next; // current pad block carries the length
    logic        wait_reg, wait_next;     // wait for core to start
    logic [2:0]  widx_reg, widx_next;

    // Block memory: 16 words of 32 bits, byte lanes written singly.
    logic [31:0] blk_mem [16];
    logic        mem_we;
    logic [5:0]  mem_waddr;
    logic [7:0]  mem_wdata;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data_reg;

    core_req_t   req;
    core_stat_t  stat;
    logic        chain_clear;
    logic [31:0] chain_word;

    logic in_fire, out_fire, is_op;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign is_op = (s_axis_tuser != OP_UNUSED);

    always_ff @(posedge aclk) begin
        if (mem_we) blk_mem[mem_waddr[5:2]][8 * (3 - mem_waddr[1:0]) +: 8] <= mem_wdata;
        rd_data_reg <= blk_mem[rd_addr];
    end

    sha_core u_core (
        .aclk(aclk), .aresetn(aresetn), .req(req), .stat(stat),
        .wd_addr(rd_addr), .wd_data(rd_data_reg),
        .chain_clear(chain_clear), .chain_idx(widx_reg), .chain_word(chain_word)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = chain_word;
    assign m_axis_tuser = widx_reg;
    assign m_axis_tlast = (widx_reg == 3'd7);

    // Padding byte for the current fill position: marker first, then zeros,
    // with the big-endian bit length in the last eight bytes of the final block.
    logic [7:0] pad_byte;
    always_comb begin
        if (!mark_reg) pad_byte = PAD_BYTE;
        else if (lenblk_reg && fill_reg >= 6'd56) pad_byte = bits_reg[8 * (63 - fill_reg) +: 8];
        else pad_byte = 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        fin_next = fin_reg;
        mark_next = mark_reg;
        lenblk_next = lenblk_reg;
        wait_next = 1'b0;
        widx_next = widx_reg;
        mem_we = 1'b0;
        mem_waddr = fill_reg;
        mem_wdata = s_axis_tdata;
        req.start = 1'b0;
        chain_clear = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && is_op) begin
                    mark_next = 1'b0;
                    if (s_axis_tuser != OP_FINISH) begin
                        mem_we = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 6'd63) begin
                            // Hash the full block first; pad afterwards if finishing.
                            req.start = 1'b1;
                            wait_next = 1'b1;
                            fin_next = (s_axis_tuser == OP_ABSORB_FINISH);
                            state_next = ST_HASH;
                        end else if (s_axis_tuser == OP_ABSORB_FINISH) begin
                            state_next = ST_PAD;
                        end
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_HASH: begin
                if (!wait_reg && !stat.busy) begin
                    if (fin_reg) state_next = ST_PAD;
                    else state_next = ST_IDLE;
                    fin_next = 1'b0;
                end
            end
            ST_PAD: begin
                mem_we = 1'b1;
                mem_wdata = pad_byte;
                if (!mark_reg) begin
                    // A marker past byte 55 leaves no room for the length here.
                    mark_next = 1'b1;
                    lenblk_next = (fill_reg < 6'd56);
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    req.start = 1'b1;
                    wait_next = 1'b1;
                    state_next = ST_PHASH;
                end
            end
            ST_PHASH: begin
                if (!wait_reg && !stat.busy) begin
                    if (lenblk_reg) begin
                        state_next = ST_OUT;
                        widx_next = '0;
                    end else begin
                        // Second block: zeros and the length.
                        state_next = ST_PAD;
                        lenblk_next = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7) begin
                        state_next = ST_IDLE;
                        chain_clear = 1'b1;
                        bits_next = '0;
                        fill_next = '0;
                        fin_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            fin_reg <= 1'b0;
            mark_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            wait_reg <= 1'b0;
            widx_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            fin_reg <= fin_next;
            mark_reg <= mark_next;
            lenblk_reg <= lenblk_next;
            wait_reg <= wait_next;
            widx_reg <= widx_next;
        end
    end
endmodule

>>> test/sha256_checker.sv
// Digest checker for the SHA-256 stream hasher: follows both streams and checks the words.
`timescale 1ns / 1ps
module sha256_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          words_pending
);
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0]  hash_state [8];
    logic [7:0]   block_bytes [64];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_ptr;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        block_bytes[fill_ptr] = b;
        fill_ptr = fill_ptr + 6'd1;
        msg_bits = msg_bits + 64'd8;
        if (fill_ptr == 6'd0) compress_block();
    endtask

    task automatic restart_message();
        hash_state = IV;
        msg_bits = '0;
        fill_ptr = '0;
    endtask

    // Pad, compress and queue the eight digest words, then start a new message.
    task automatic finish_message();
        int p;
        p = fill_ptr;
        block_bytes[p] = PAD_BYTE;
        p++;
        if (p > 56) begin
            while (p < 64) begin block_bytes[p] = 8'h00; p++; end
            compress_block();
            p = 0;
        end
        while (p < 56) begin block_bytes[p] = 8'h00; p++; end
        for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
        restart_message();
    endtask

    task automatic report(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    initial begin
        error_count = 0;
        words_pending = 0;
        restart_message();
    end

    always @(posedge aclk) begin
        digest_word_t exp_word;
        if (!aresetn) begin
            restart_message();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    OP_ABSORB:        absorb_byte(s_axis_tdata);
                    OP_ABSORB_FINISH: begin absorb_byte(s_axis_tdata); finish_message(); end
                    OP_FINISH:        finish_message();
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_queue.size() == 0) begin
                    report($sformatf("unexpected word %h", m_axis_tdata));
                end else begin
                    exp_word = digest_queue.pop_front();
                    if (m_axis_tdata !== exp_word.word)
                        report($sformatf("word %h, want %h", m_axis_tdata, exp_word.word));
                    if (m_axis_tuser !== exp_word.index)
                        report($sformatf("index %0d, want %0d", m_axis_tuser, exp_word.index));
                    if (m_axis_tlast !== exp_word.last)
                        report($sformatf("tlast %b, want %b", m_axis_tlast, exp_word.last));
                end
            end
        end
        words_pending <= digest_queue.size();
    end
endmodule

>>> test/tb_top.sv
// Stimulus and verdict for the SHA-256 stream hasher.
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_ABSORB;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          error_count;
    int          words_pending;
    int          idle_pct = 0;   // chance of the sender holding off
    int          stall_pct = 0;  // chance of the receiver stalling
    int          quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sha256_stream_hasher u_top (.*);

    sha256_checker u_chk (.*);

    // Receiver: redraw tready each cycle.
    always @(posedge aclk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one transaction and hold it until tready is seen high after an edge; drop tvalid only while idling.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_message(input int len, input bit tail_byte);
        for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
        if (tail_byte) send_item(OP_ABSORB_FINISH, 8'($urandom));
        else send_item(OP_FINISH, 8'($urandom));
    endtask

    initial begin
        int len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, byte extremes, unused op, boundary lengths.
        send_item(OP_FINISH, 8'h00);
        send_item(OP_ABSORB_FINISH, 8'hff);
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_UNUSED, 8'ha5);
        send_item(OP_ABSORB_FINISH, 8'h55);
        send_item(OP_UNUSED, 8'hff);
        send_item(OP_ABSORB_FINISH, 8'haa);
        // Lengths around the extra-block boundary and a whole block.
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);

        // Random: mostly short messages with the occasional unused op.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 25 : 67) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 25 : 67) : 0;
            for (int n = 0; n < 30; n += len + 1) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(70, 130) : $urandom_range(0, 20);
                if ($urandom_range(15) == 0) send_item(OP_UNUSED, 8'($urandom));
                send_message(len, 1'($urandom_range(1)));
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
src/sha_pkg.sv
src/sha_core.sv
src/sha256_stream_hasher.sv
test/sha256_checker.sv
test/tb_top.sv
